// File: rtl/core/cartesian_to_spherical_macros.svh
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// The property holds at every sampled edge.
`define CTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the condition holds, the consequence holds at the following sampled edge.
`define CTS_ASSERT_NEXT(name, cond, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cts_pkg.sv
`default_nettype none

package cts_pkg;

  localparam int COORD_BITS = 16;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int TABLE_LEN = 24;
  localparam int FRAC_BITS = 8;

  // CORDIC datapath: coordinate plus fraction bits plus headroom for the gain.
  localparam int CW = COORD_BITS + FRAC_BITS + 4;
  // Magnitude after the sign clamp.
  localparam int MW = CW - 1;
  // Angle accumulator, 2^31 is pi.
  localparam int AW = 34;
  // Gain constant width (Q23).
  localparam int GW = 23;
  localparam int PW = MW + GW;

  localparam longint unsigned KINF_Q23 = 64'd5093997;
  localparam longint unsigned GAIN_EXTRA = (KINF_Q23 * 64'd2) / 64'd3;
  localparam longint unsigned GAIN_FULL = KINF_Q23 + (GAIN_EXTRA >> (2 * CORDIC_ITERATIONS));
  localparam logic [GW-1:0] GAIN = GW'(GAIN_FULL);
  localparam logic [PW:0] GAIN_HALF = (PW + 1)'(1) << (GW - 1);

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [AW-1:0] aw_t;
  typedef logic [MW-1:0] mag_t;

  localparam aw_t HALF_TURN = AW'(64'h8000_0000);
  localparam aw_t QUARTER_TURN = AW'(64'h4000_0000);
  localparam aw_t ANGLE_HALF_LSB = AW'(64'h8000);

  localparam aw_t ATAN_TAB [TABLE_LEN] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
    34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
    34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
    34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051
  };

  // Sideband that travels with each point through the pipeline.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic                         xy_zero;
    logic                         rxy_zero;
    logic [15:0]                  azimuth;
  } side_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    aw_t ang;
  } pre_t;

  // Quarter-turn rotation that brings the vector into the right half plane.
  function automatic pre_t pre_rotate(input cw_t x, input cw_t y);
    pre_t r;
    r.x = x;
    r.y = y;
    r.ang = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.ang = QUARTER_TURN;
      end else begin
        r.x = -y;
        r.y = x;
        r.ang = -QUARTER_TURN;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cts_point_if.sv
`default_nettype none

interface cts_point_if import cts_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cts_sphere_if.sv
`default_nettype none

interface cts_sphere_if;
  logic               valid;
  logic               ready;
  logic        [15:0] radius;
  logic        [15:0] polar_angle;
  logic signed [15:0] azimuth;

  modport source (output valid, radius, polar_angle, azimuth, input ready);
  modport sink (input valid, radius, polar_angle, azimuth, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cts_vector_pass.sv
`default_nettype none

// One CORDIC vectoring pass, one registered micro-rotation per stage.
module cts_vector_pass import cts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cw_t   x_i,
  input  cw_t   y_i,
  input  aw_t   ang_i,
  input  side_t side_i,
  output logic  valid_o,
  output cw_t   x_o,
  output aw_t   ang_o,
  output side_t side_o
);

  logic  v_q [CORDIC_ITERATIONS];
  cw_t   x_q [CORDIC_ITERATIONS];
  cw_t   y_q [CORDIC_ITERATIONS-1];
  aw_t   a_q [CORDIC_ITERATIONS];
  side_t s_q [CORDIC_ITERATIONS];

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_stage
    logic  vin;
    cw_t   xin;
    cw_t   yin;
    aw_t   ain;
    side_t sin;
    cw_t   x_d;
    cw_t   y_d;
    aw_t   a_d;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign xin = x_i;
      assign yin = y_i;
      assign ain = ang_i;
      assign sin = side_i;
    end else begin : g_rest
      assign vin = v_q[i-1];
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign ain = a_q[i-1];
      assign sin = s_q[i-1];
    end

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
      if (!yin[CW-1]) begin
        x_d = xin + (yin >>> i);
        y_d = yin - (xin >>> i);
        a_d = ain + ATAN_TAB[i];
      end else begin
        x_d = xin - (yin >>> i);
        y_d = yin + (xin >>> i);
        a_d = ain - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        a_q[i] <= a_d;
        s_q[i] <= sin;
      end
    end

    if (i < CORDIC_ITERATIONS - 1) begin : g_keep_y
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[i] <= y_d;
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_ITERATIONS-1];
  assign x_o = x_q[CORDIC_ITERATIONS-1];
  assign ang_o = a_q[CORDIC_ITERATIONS-1];
  assign side_o = s_q[CORDIC_ITERATIONS-1];

endmodule

`default_nettype wire

// File: rtl/core/cts_gain_comp.sv
`default_nettype none

// CORDIC gain removal: registered product, rounding on the way out.
module cts_gain_comp import cts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  cw_t   x_i,
  input  aw_t   ang_i,
  input  side_t side_i,
  output logic  valid_o,
  output mag_t  mag_o,
  output aw_t   ang_o,
  output side_t side_o
);

  mag_t          mag;
  logic [PW-1:0] prod_q;
  logic [PW:0]   sum;
  logic          valid_q;
  aw_t           ang_q;
  side_t         side_q;

  // A negative residue counts as zero length.
  assign mag = x_i[CW-1] ? '0 : x_i[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(mag) * PW'(GAIN);
      ang_q  <= ang_i;
      side_q <= side_i;
    end
  end

  assign sum = {1'b0, prod_q} + GAIN_HALF;
  assign mag_o = sum[GW+MW-1:GW];
  assign valid_o = valid_q;
  assign ang_o = ang_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// File: rtl/core/cartesian_to_spherical.sv
// Channel   Dir  Word fields
// point_i   in   coord_x, coord_y, coord_z (signed 16 bit each)
// sphere_o  out  radius, polar_angle, azimuth (16 bit each)
//
// One point enters per cycle while sphere_o is not stalled. A result passes the
// input register, the first unrolled CORDIC pass and gain multiply, the middle
// register, the second pass and gain multiply and then the output register.
// rst_ni clears the valid bits only. When sphere_o holds a word that is not
// taken, the whole pipeline freezes and point_i.ready drops; nothing is lost.
`default_nettype none

module cartesian_to_spherical import cts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cts_point_if.sink     point_i,
  cts_sphere_if.source  sphere_o
);

  logic  en;
  logic  out_valid_q;

  // Input stage: scale to fixed point and pre-rotate for the xy pass.
  pre_t  pre1;
  side_t side0_d;
  logic  v0_q;
  cw_t   x0_q;
  cw_t   y0_q;
  aw_t   a0_q;
  side_t s0_q;

  assign en = !out_valid_q || sphere_o.ready;
  assign point_i.ready = en;

  assign pre1 = pre_rotate(CW'(point_i.coord_x) <<< FRAC_BITS,
                           CW'(point_i.coord_y) <<< FRAC_BITS);

  always_comb begin
    side0_d = '0;
    side0_d.z = point_i.coord_z;
    side0_d.xy_zero = (point_i.coord_x == '0) && (point_i.coord_y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= pre1.x;
      y0_q <= pre1.y;
      a0_q <= pre1.ang;
      s0_q <= side0_d;
    end
  end

  // First pass: (x, y) gives the xy length and the azimuth.
  logic  v1;
  cw_t   x1;
  aw_t   a1;
  side_t s1;

  cts_vector_pass u_pass_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .x_i     (x0_q),
    .y_i     (y0_q),
    .ang_i   (a0_q),
    .side_i  (s0_q),
    .valid_o (v1),
    .x_o     (x1),
    .ang_o   (a1),
    .side_o  (s1)
  );

  logic  vg1;
  mag_t  rxy;
  aw_t   ag1;
  side_t sg1;

  cts_gain_comp u_gain_xy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .x_i     (x1),
    .ang_i   (a1),
    .side_i  (s1),
    .valid_o (vg1),
    .mag_o   (rxy),
    .ang_o   (ag1),
    .side_o  (sg1)
  );

  // Middle stage: round the azimuth, set up the (z, rxy) pass.
  pre_t  pre2;
  aw_t   az_sum;
  side_t side2_d;
  logic  v2_q;
  cw_t   x2_q;
  cw_t   y2_q;
  aw_t   a2_q;
  side_t s2_q;

  assign pre2 = pre_rotate(CW'(sg1.z) <<< FRAC_BITS, cw_t'({1'b0, rxy}));
  assign az_sum = ag1 + ANGLE_HALF_LSB;

  always_comb begin
    side2_d = sg1;
    side2_d.rxy_zero = (rxy == '0);
    side2_d.azimuth = sg1.xy_zero ? '0 : az_sum[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= vg1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q <= pre2.x;
      y2_q <= pre2.y;
      a2_q <= pre2.ang;
      s2_q <= side2_d;
    end
  end

  // Second pass: (z, rxy) gives the radius and the polar angle.
  logic  v3;
  cw_t   x3;
  aw_t   a3;
  side_t s3;

  cts_vector_pass u_pass_rz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .x_i     (x2_q),
    .y_i     (y2_q),
    .ang_i   (a2_q),
    .side_i  (s2_q),
    .valid_o (v3),
    .x_o     (x3),
    .ang_o   (a3),
    .side_o  (s3)
  );

  logic  vg2;
  mag_t  rho_c;
  aw_t   ag2;
  side_t sg2;

  cts_gain_comp u_gain_rz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3),
    .x_i     (x3),
    .ang_i   (a3),
    .side_i  (s3),
    .valid_o (vg2),
    .mag_o   (rho_c),
    .ang_o   (ag2),
    .side_o  (sg2)
  );

  // Output stage: radius rounding and saturation, polar clamp.
  logic signed [COORD_BITS:0] z_ext;
  logic signed [COORD_BITS:0] z_abs;
  mag_t                       rho;
  logic [MW:0]                rho_sum;
  logic [MW-FRAC_BITS:0]      rho_int;
  logic [15:0]                radius_d;
  aw_t                        pol_clamped;
  aw_t                        pol_sum;
  logic [15:0]                polar_d;
  logic [15:0]                radius_q;
  logic [15:0]                polar_q;
  logic [15:0]                azimuth_q;

  assign z_ext = (COORD_BITS + 1)'(sg2.z);
  assign z_abs = (z_ext < 0) ? -z_ext : z_ext;

  // With no xy length the point lies on the z axis and the pass is bypassed.
  assign rho = sg2.rxy_zero ? (MW'(z_abs) << FRAC_BITS) : rho_c;
  assign rho_sum = (MW + 1)'(rho) + ((MW + 1)'(1) << (FRAC_BITS - 1));
  assign rho_int = rho_sum[MW:FRAC_BITS];
  assign radius_d = (rho_int > (MW - FRAC_BITS + 1)'(16'hFFFF)) ? 16'hFFFF : rho_int[15:0];

  always_comb begin
    if (ag2 < 0) begin
      pol_clamped = '0;
    end else if (ag2 > HALF_TURN) begin
      pol_clamped = HALF_TURN;
    end else begin
      pol_clamped = ag2;
    end
  end

  assign pol_sum = pol_clamped + ANGLE_HALF_LSB;

  always_comb begin
    if (sg2.rxy_zero) begin
      polar_d = sg2.z[COORD_BITS-1] ? 16'h8000 : 16'h0000;
    end else begin
      polar_d = pol_sum[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vg2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      radius_q  <= radius_d;
      polar_q   <= polar_d;
      azimuth_q <= sg2.azimuth;
    end
  end

  assign sphere_o.valid = out_valid_q;
  assign sphere_o.radius = radius_q;
  assign sphere_o.polar_angle = polar_q;
  assign sphere_o.azimuth = azimuth_q;

endmodule

`default_nettype wire

// File: rtl/core/cts_checker.sv
`default_nettype none
`include "cartesian_to_spherical_macros.svh"

module cts_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic        [15:0] radius_i,
  input wire logic        [15:0] polar_angle_i,
  input wire logic signed [15:0] azimuth_i
);

  `CTS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(radius_i) && $stable(polar_angle_i) && $stable(azimuth_i), "result word changed while stalled")

  // The input side only backs up when the output word is held up.
  `CTS_ASSERT(a_stall_cause, !in_ready_i |-> (out_valid_i && !out_ready_i), "input stalled without output back pressure")

  `CTS_ASSERT(a_polar_range, out_valid_i |-> (polar_angle_i <= 16'd32768), "polar angle beyond pi")

  // Only the origin rounds to a zero radius, and it has zero angles.
  `CTS_ASSERT(a_origin, (out_valid_i && (radius_i == 16'd0)) |-> ((polar_angle_i == 16'd0) && (azimuth_i == 16'sd0)), "zero radius with nonzero angle")

endmodule

bind cartesian_to_spherical cts_checker u_cts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (point_i.ready),
  .out_valid_i   (sphere_o.valid),
  .out_ready_i   (sphere_o.ready),
  .radius_i      (sphere_o.radius),
  .polar_angle_i (sphere_o.polar_angle),
  .azimuth_i     (sphere_o.azimuth)
);

`default_nettype wire

// File: tb/cartesian_to_spherical_tb.sv
module cartesian_to_spherical_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::COORD_BITS;
  import cts_pkg::CORDIC_ITERATIONS;
  import cts_pkg::FRAC_BITS;

  localparam int ATAN_LEN = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_POINTS = 550;
  localparam int DRAIN_CYCLES = 60;
  localparam longint QUARTER = 64'sh4000_0000;
  localparam longint HALF = 64'sh8000_0000;
  localparam longint unsigned KINF = 64'd5093997;
  localparam longint unsigned GAIN_Q23 = KINF + ((KINF * 64'd2 / 64'd3) >> (2 * CORDIC_ITERATIONS));

  localparam longint ARCTAN [ATAN_LEN] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   wait_drain;
  } point_t;

  typedef struct packed {
    logic        [15:0] radius;
    logic        [15:0] polar_angle;
    logic signed [15:0] azimuth;
  } sphere_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_HICCUP} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  cts_point_if  pt_if ();
  cts_sphere_if sp_if ();

  cartesian_to_spherical DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (pt_if),
    .sphere_o (sp_if)
  );

  point_t   point_queue [$];
  sphere_t  sphere_exp [$];
  logic     pt_taken = 1'b0;
  int       error_count = 0;
  int       cycle_count = 0;
  int       gap_left = 0;
  int       burst_left = 1;
  int       rx_tick = 0;
  rx_mode_e rx_mode = RX_FREE;

  always #5 clk_i = ~clk_i;

  // Vectoring CORDIC: rotates (xi, yi) onto the positive x axis.
  function automatic void cordic_vector(input longint xi, input longint yi,
                                        output longint unsigned mag, output longint ang);
    longint vx, vy, nx, ny, a, t;
    int     i;
    vx = xi;
    vy = yi;
    a = 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy;
        vy = -t;
        a = QUARTER;
      end else begin
        vx = -vy;
        vy = t;
        a = -QUARTER;
      end
    end
    for (i = 0; i < CORDIC_ITERATIONS && i < ATAN_LEN; i++) begin
      if (vy >= 0) begin
        nx = vx + (vy >>> i);
        ny = vy - (vx >>> i);
        a += ARCTAN[i];
      end else begin
        nx = vx - (vy >>> i);
        ny = vy + (vx >>> i);
        a -= ARCTAN[i];
      end
      vx = nx;
      vy = ny;
    end
    mag = (vx < 0) ? 64'd0 : longint'(unsigned'(vx));
    ang = a;
  endfunction

  function automatic longint unsigned apply_gain(input longint unsigned mag);
    return (mag * GAIN_Q23 + (64'd1 << 22)) >> 23;
  endfunction

  function automatic sphere_t to_sphere(input coord_t cx, input coord_t cy, input coord_t cz);
    sphere_t          s;
    longint           x, y, z, az, pol, scaled;
    longint unsigned  m, rxy, rho, rad;
    x = longint'(cx);
    y = longint'(cy);
    z = longint'(cz);
    s = '0;
    az = 0;
    rxy = 0;
    if (x == 0 && y == 0 && z == 0) return s;
    if (x != 0 || y != 0) begin
      cordic_vector(x * 256, y * 256, m, az);
      rxy = apply_gain(m);
    end
    if (rxy == 0) begin
      rho = longint'(unsigned'((z < 0) ? -z : z)) << FRAC_BITS;
      s.polar_angle = (z < 0) ? 16'd32768 : 16'd0;
    end else begin
      cordic_vector(z * 256, longint'(rxy), m, pol);
      rho = apply_gain(m);
      // The residue of the second pass may step just past either pole.
      if (pol < 0) pol = 0;
      if (pol > HALF) pol = HALF;
      scaled = (pol + 32768) >>> 16;
      s.polar_angle = scaled[15:0];
    end
    rad = (rho + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    s.radius = (rad > 64'd65535) ? 16'hFFFF : rad[15:0];
    if (x != 0 || y != 0) begin
      scaled = (az + 32768) >>> 16;
      s.azimuth = scaled[15:0];
    end
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d (0x%04h), actual %0d (0x%04h)",
               $time, name, want, want, got, got);
    end
  endfunction

  function automatic coord_t rand_span(input int lo, input int hi);
    return coord_t'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'(-32768);
      1: return coord_t'(-1);
      2: return coord_t'(0);
      3: return coord_t'(1);
      default: return coord_t'(32767);
    endcase
  endfunction

  task automatic add_point(input int x, input int y, input int z, input logic drain = 1'b0);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.wait_drain = drain;
    point_queue.push_back(p);
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(negedge clk_i) begin
    point_t nxt;
    if (rst_ni && (!pt_if.valid || pt_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        pt_if.valid <= 1'b0;
      end else if (point_queue.size() != 0 &&
                   !(point_queue[0].wait_drain && sphere_exp.size() != 0)) begin
        nxt = point_queue.pop_front();
        pt_if.valid   <= 1'b1;
        pt_if.coord_x <= nxt.x;
        pt_if.coord_y <= nxt.y;
        pt_if.coord_z <= nxt.z;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(20, 45);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern changes every so often.
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE: sp_if.ready <= 1'b1;
      RX_COIN: sp_if.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: sp_if.ready <= (rx_tick % 5 == 0);
      default: sp_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    sphere_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else if (rst_ni) begin
      pt_taken <= pt_if.valid && pt_if.ready;
      if (pt_if.valid && pt_if.ready)
        sphere_exp.push_back(to_sphere(pt_if.coord_x, pt_if.coord_y, pt_if.coord_z));
      if (sp_if.valid && sp_if.ready) begin
        if (sphere_exp.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, actual %0d %0d %0d", $time,
                   sp_if.radius, sp_if.polar_angle, sp_if.azimuth);
        end else begin
          want = sphere_exp.pop_front();
          check_field("radius", want.radius, sp_if.radius);
          check_field("polar_angle", want.polar_angle, sp_if.polar_angle);
          check_field("azimuth", want.azimuth, sp_if.azimuth);
        end
      end
    end
  end

  initial begin
    int     kind;
    coord_t rx, ry, rz;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    pt_if.valid = 1'b0;
    pt_if.coord_x = '0;
    pt_if.coord_y = '0;
    pt_if.coord_z = '0;
    sp_if.ready = 1'b0;

    // Origin, points on the z axis, azimuth of pi, the coordinate extremes and small points on and off the axes.
    add_point(0, 0, 0);
    add_point(0, 0, 1);
    add_point(0, 0, -1);
    add_point(0, 0, 32767);
    add_point(0, 0, -32768);
    add_point(-32768, 0, 0);
    add_point(-1, 0, 5);
    add_point(32767, 32767, 32767);
    add_point(-32768, -32768, -32768);
    add_point(-32768, -32768, 32767);
    add_point(32767, -32768, 0);
    add_point(-32768, 32767, -1);
    add_point(1, 0, 0);
    add_point(0, 1, 0);
    add_point(0, -1, 0);
    add_point(-1, 1, 0);
    add_point(-1, -1, 0);
    add_point(1, 0, 32767);
    add_point(-1, 0, -32768);
    add_point(0, 1, -32768);
    add_point(32767, 0, -32768);
    add_point(100, -200, 300);
    add_point(5, -3, -7);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3, 4: begin
          rx = coord_t'($urandom());
          ry = coord_t'($urandom());
          rz = coord_t'($urandom());
        end
        5, 6: begin
          rx = rand_span(-64, 64);
          ry = rand_span(-64, 64);
          rz = rand_span(-64, 64);
        end
        7: begin
          // Close to the z axis, where the polar angle nears a pole.
          rx = rand_span(-3, 3);
          ry = rand_span(-3, 3);
          rz = coord_t'($urandom());
        end
        8: begin
          rx = coord_t'($urandom());
          ry = coord_t'($urandom());
          rz = coord_t'($urandom());
          case ($urandom_range(0, 2))
            0: rx = '0;
            1: ry = '0;
            default: rz = '0;
          endcase
        end
        default: begin
          rx = extreme_coord();
          ry = extreme_coord();
          rz = extreme_coord();
        end
      endcase
      add_point(rx, ry, rz, n == 0 || n == RANDOM_POINTS / 2 || $urandom_range(0, 149) == 0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (point_queue.size() != 0 || pt_if.valid);
    while (sphere_exp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: cartesian_to_spherical.f
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_point_if.sv
rtl/core/cts_sphere_if.sv
rtl/core/cts_vector_pass.sv
rtl/core/cts_gain_comp.sv
rtl/core/cartesian_to_spherical.sv
rtl/core/cts_checker.sv
tb/cartesian_to_spherical_tb.sv
